// ----- hw/rtl/lppd_pkg.sv -----
package lppd_pkg;

  localparam int unsigned CHANNELS_DEF = 16;

  localparam logic [7:0]  HDR_SHORT    = 8'hC1;
  localparam logic [7:0]  HDR_LONG     = 8'hC2;
  localparam logic [15:0] MIN_SHORT    = 16'd3;
  localparam logic [15:0] MIN_LONG     = 16'd4;
  localparam logic [15:0] MAX_SIZE_RST = 16'd8192;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_HDR = 3'd1;
  localparam logic [2:0] ST_BAD_LEN = 3'd2;
  localparam logic [2:0] ST_DISCARD = 3'd3;
  localparam logic [2:0] ST_RESTART = 3'd4;

  // classified item as it travels from front to back
  typedef struct packed {
    logic [3:0] chan;
    logic [7:0] data;
    logic       restart;
    logic       hdr_short;
    logic       hdr_long;
  } item_t;

  typedef struct packed {
    logic [3:0]  chan;
    logic [7:0]  data;
    logic [15:0] position;
    logic [7:0]  command_code;
    logic [15:0] packet_size;
    logic        first;
    logic        last;
    logic [2:0]  status;
  } result_t;

endpackage

// ----- hw/rtl/lppd_front.sv -----
module lppd_front
  import lppd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_channel,
  input  logic [7:0] in_data_byte,
  input  logic       in_restart,
  input  logic       hold,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  item_t      cls;

  // header classification
  always_comb begin
    cls.chan      = in_channel;
    cls.data      = in_data_byte;
    cls.restart   = in_restart;
    cls.hdr_short = (in_data_byte == HDR_SHORT);
    cls.hdr_long  = (in_data_byte == HDR_LONG);
  end

  assign in_ready = (count_r != 2'd2) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- hw/rtl/lppd_back.sv -----
module lppd_back
  import lppd_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        clearing,
  input  logic [15:0] max_size,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LEN_A = 3'd1,
    PH_LEN_B = 3'd2,
    PH_CMD   = 3'd3,
    PH_BODY  = 3'd4,
    PH_ERROR = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        long_hdr;
    logic [15:0] exp_size;
    logic [15:0] cnt;
    logic [7:0]  cmd;
  } chan_state_t;

  localparam chan_state_t ST_ZERO = '{phase: PH_IDLE, long_hdr: 1'b0, exp_size: 16'd0,
                                      cnt: 16'd0, cmd: 8'd0};

  // channel number to state slot, folded at elaboration
  logic [IDX_W-1:0] idx_tab [16];
  for (genvar g = 0; g < 16; g++) begin : g_idx
    assign idx_tab[g] = IDX_W'(g % CHANNELS);
  end

  chan_state_t      mem [CHANNELS];
  chan_state_t      rd_data_r;
  chan_state_t      byp_data_r;
  logic             byp_r;
  logic             clr_active_r;
  logic [IDX_W-1:0] clr_idx_r;
  logic             p_valid_r;
  item_t            p_item_r;
  logic [IDX_W-1:0] p_idx_r;
  logic             out_valid_r;
  result_t          out_res_r;

  logic             p_adv;
  logic [IDX_W-1:0] q_idx;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  chan_state_t      wr_data;
  chan_state_t      cur;
  chan_state_t      ns;
  result_t          res;
  logic [15:0]      size_v;
  logic [15:0]      min_v;
  logic [16:0]      pos_inc;

  assign clearing  = clr_active_r;
  assign q_idx     = idx_tab[q_item.chan];
  assign p_adv     = p_valid_r && (!out_valid_r || out_ready);
  assign q_pop     = q_valid && !clr_active_r && (!p_valid_r || p_adv);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign wr_en   = clr_active_r || p_adv;
  assign wr_idx  = clr_active_r ? clr_idx_r : p_idx_r;
  assign wr_data = clr_active_r ? ST_ZERO : ns;

  // a write landing on the slot being read is forwarded
  assign cur = byp_r ? byp_data_r : rd_data_r;

  always_comb begin
    ns               = cur;
    res.chan         = p_item_r.chan;
    res.data         = p_item_r.data;
    res.position     = 16'd0;
    res.command_code = 8'd0;
    res.packet_size  = 16'd0;
    res.first        = 1'b0;
    res.last         = 1'b0;
    res.status       = ST_OK;
    pos_inc          = {1'b0, cur.cnt} + 17'd1;
    size_v           = 16'd0;
    min_v            = cur.long_hdr ? MIN_LONG : MIN_SHORT;
    if (p_item_r.restart) begin
      ns         = ST_ZERO;
      res.status = ST_RESTART;
    end else begin
      case (cur.phase)
        PH_IDLE: begin
          if (p_item_r.hdr_short || p_item_r.hdr_long) begin
            ns.long_hdr = p_item_r.hdr_long;
            ns.exp_size = 16'd0;
            ns.cmd      = 8'd0;
            ns.cnt      = 16'd1;
            ns.phase    = PH_LEN_A;
            res.first   = 1'b1;
          end else begin
            ns.phase   = PH_ERROR;
            res.status = ST_BAD_HDR;
          end
        end
        PH_LEN_A, PH_LEN_B: begin
          res.position = cur.cnt;
          if (cur.phase == PH_LEN_A && cur.long_hdr) begin
            ns.exp_size = {p_item_r.data, 8'd0};
            ns.cnt      = pos_inc[15:0];
            ns.phase    = PH_LEN_B;
          end else begin
            size_v = (cur.phase == PH_LEN_B) ? (cur.exp_size | {8'd0, p_item_r.data})
                                             : {8'd0, p_item_r.data};
            ns.exp_size     = size_v;
            res.packet_size = size_v;
            if (size_v < min_v || size_v > max_size) begin
              ns.phase   = PH_ERROR;
              res.status = ST_BAD_LEN;
            end else begin
              ns.cnt   = pos_inc[15:0];
              ns.phase = PH_CMD;
            end
          end
        end
        PH_CMD, PH_BODY: begin
          res.position     = cur.cnt;
          res.command_code = (cur.phase == PH_CMD) ? p_item_r.data : cur.cmd;
          res.packet_size  = cur.exp_size;
          if (pos_inc >= {1'b0, cur.exp_size}) begin
            res.last = 1'b1;
            ns       = ST_ZERO;
          end else begin
            ns.cmd   = res.command_code;
            ns.cnt   = pos_inc[15:0];
            ns.phase = PH_BODY;
          end
        end
        default: begin
          res.status = ST_DISCARD;
        end
      endcase
    end
  end

  // state memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (q_pop) begin
      rd_data_r  <= mem[q_idx];
      byp_r      <= wr_en && (wr_idx == q_idx);
      byp_data_r <= wr_data;
    end
    if (q_pop) begin
      p_item_r <= q_item;
      p_idx_r  <= q_idx;
    end
    if (p_adv) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      p_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        if (clr_idx_r == IDX_W'(CHANNELS - 1)) begin
          clr_active_r <= 1'b0;
        end else begin
          clr_idx_r <= clr_idx_r + 1'b1;
        end
      end
      if (q_pop) begin
        p_valid_r <= 1'b1;
      end else if (p_adv) begin
        p_valid_r <= 1'b0;
      end
      if (p_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/length_prefixed_packet_deframer.sv -----
// length-prefixed packet deframer
// input channel (in_valid/in_ready): one byte of one connection per item, with
//   its channel number and a restart flag that clears that channel's parser
// result channel (out_valid/out_ready): one item per input item, in order,
//   echoing channel and byte with position, command code, packet size,
//   first/last marks and a status code
// config channel (cfg_valid/cfg_ready): always ready, writes max_packet_size;
//   write it only while no item is in flight
// structure: front classifies header bytes and holds a two-entry queue; back
//   reads the per-channel state memory, runs the parser and fills the
//   output register
// path: an accepted item passes through a queue entry, the parser input
//   register and the output register, in that order
// throughput: one item per cycle while out_ready stays high, also for runs on
//   the same channel, since the back forwards a state write to a read of the same slot
// reset: after rst_n goes high the back clears the state memory one channel
//   per cycle, with in_ready held low; max_packet_size returns to 8192
// stall: when out_ready is low the output register holds, the back stage
//   waits and the queue fills; in_ready drops once both queue entries are full
module length_prefixed_packet_deframer
  import lppd_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_channel,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_channel,
  output logic [7:0]  out_byte,
  output logic [15:0] out_position,
  output logic [7:0]  out_command_code,
  output logic [15:0] out_packet_size,
  output logic        out_first,
  output logic        out_last,
  output logic [2:0]  out_status,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_packet_size
);

  logic        q_valid;
  item_t       q_item;
  logic        q_pop;
  logic        clearing;
  result_t     res;
  logic [15:0] max_size_r;

  // max packet size register, written any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_size_r <= cfg_max_packet_size;
    end
  end

  // front: accept and classify, queue toward the parser
  lppd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_channel   (in_channel),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .hold         (clearing),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // back: per-channel state, parser and output register
  lppd_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .max_size  (max_size_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_channel      = res.chan;
  assign out_byte         = res.data;
  assign out_position     = res.position;
  assign out_command_code = res.command_code;
  assign out_packet_size  = res.packet_size;
  assign out_first        = res.first;
  assign out_last         = res.last;
  assign out_status       = res.status;

`ifndef SYNTHESIS
  // no byte gets in while the state memory is being cleared
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("item accepted during state clear");

  // a header byte always opens at offset zero with no error
  a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_first) |-> (out_position == 16'd0 && out_status == ST_OK))
    else $error("first mark with nonzero position or status");

  // the closing byte belongs to a sized packet and lands at size minus one
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |->
      (out_status == ST_OK && out_packet_size != 16'd0 &&
       out_position == out_packet_size - 16'd1))
    else $error("last mark inconsistent with packet size");

  // error results carry no packet marks
  a_err_no_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (!out_first && !out_last))
    else $error("packet mark on an error result");
`endif

endmodule

// ----- test/length_prefixed_packet_deframer_test.sv -----
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_test;
  import lppd_pkg::*;

  localparam int unsigned CHANNELS    = CHANNELS_DEF;
  localparam int unsigned PLAN_DEPTH  = 48;   // room for the longest planned byte run per channel
  localparam int unsigned HOLD_CYCLES = 400;  // long receiver hold-off
  localparam int unsigned DRAIN_WAIT  = 8;    // settling margin after the last echo
  localparam int unsigned QUIET_LIMIT = 3000; // cycles without any handshake

  // parser phase of one channel
  typedef enum logic [2:0] {
    AWAIT_HDR,
    AWAIT_LEN1,
    AWAIT_LEN2,
    AWAIT_CMD,
    IN_BODY,
    DISCARDING
  } parse_phase_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_channel;
  logic [7:0]  in_data_byte;
  logic        in_restart;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_channel;
  logic [7:0]  out_byte;
  logic [15:0] out_position;
  logic [7:0]  out_command_code;
  logic [15:0] out_packet_size;
  logic        out_first;
  logic        out_last;
  logic [2:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_max_packet_size;

  length_prefixed_packet_deframer #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_channel         (in_channel),
    .in_data_byte       (in_data_byte),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel        (out_channel),
    .out_byte           (out_byte),
    .out_position       (out_position),
    .out_command_code   (out_command_code),
    .out_packet_size    (out_packet_size),
    .out_first          (out_first),
    .out_last           (out_last),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_packet_size(cfg_max_packet_size)
  );

  always #5 clk = ~clk;

  // parser state mirrored per channel, plus the size limit
  parse_phase_t chan_phase [CHANNELS];
  logic         chan_long  [CHANNELS];
  logic [15:0]  chan_size  [CHANNELS];
  logic [15:0]  chan_count [CHANNELS];
  logic [7:0]   chan_cmd   [CHANNELS];
  logic [15:0]  max_size_cfg;

  // byte echoes predicted but not yet seen on the result port
  result_t pending_echoes [$];

  // planned byte runs for the random traffic, {restart, byte} per entry
  logic [8:0]  plan_mem [CHANNELS][PLAN_DEPTH];
  int unsigned plan_len [CHANNELS];
  int unsigned plan_idx [CHANNELS];

  // idling knobs, percent of sent bytes that start a gap or of cycles that start a stall
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned holds_asked;

  // run statistics
  int unsigned bytes_sent;
  int unsigned echoes_seen;
  int unsigned bad_echoes;
  int unsigned packets_done;
  int unsigned framing_errors;
  int unsigned restarts;
  int unsigned limits_used;
  int unsigned input_stalls;
  int unsigned quiet_cycles;

  function automatic void clear_parser(input int unsigned c);
    chan_phase[c] = AWAIT_HDR;
    chan_long[c]  = 1'b0;
    chan_size[c]  = '0;
    chan_count[c] = '0;
    chan_cmd[c]   = '0;
  endfunction

  // advances one channel's parser by one byte and returns the echo it causes
  function automatic result_t deframe_byte(input logic [3:0] ch, input logic [7:0] b,
                                           input logic rs);
    result_t     r;
    int unsigned c;
    logic [15:0] pos;
    logic [15:0] size;
    logic [15:0] min_len;
    c = ch % CHANNELS;
    r = '0;
    r.chan = ch;
    r.data = b;
    r.status = ST_OK;
    if (rs) begin
      clear_parser(c);
      r.status = ST_RESTART;
      restarts++;
    end else begin
      pos = chan_count[c];
      case (chan_phase[c])
        AWAIT_HDR: begin
          if (b == HDR_SHORT || b == HDR_LONG) begin
            chan_long[c]  = (b == HDR_LONG);
            chan_size[c]  = '0;
            chan_cmd[c]   = '0;
            chan_count[c] = 16'd1;
            chan_phase[c] = AWAIT_LEN1;
            r.first = 1'b1;
          end else begin
            chan_phase[c] = DISCARDING;
            r.status = ST_BAD_HDR;
            framing_errors++;
          end
        end
        AWAIT_LEN1, AWAIT_LEN2: begin
          r.position = pos;
          if (chan_phase[c] == AWAIT_LEN1 && chan_long[c]) begin
            // high length byte of a long header
            chan_size[c]  = {b, 8'h00};
            chan_count[c] = pos + 16'd1;
            chan_phase[c] = AWAIT_LEN2;
          end else begin
            size = (chan_phase[c] == AWAIT_LEN2) ? (chan_size[c] | {8'h00, b}) : {8'h00, b};
            chan_size[c] = size;
            r.packet_size = size;
            min_len = chan_long[c] ? MIN_LONG : MIN_SHORT;
            if (size < min_len || size > max_size_cfg) begin
              chan_phase[c] = DISCARDING;
              r.status = ST_BAD_LEN;
              framing_errors++;
            end else begin
              chan_count[c] = pos + 16'd1;
              chan_phase[c] = AWAIT_CMD;
            end
          end
        end
        AWAIT_CMD, IN_BODY: begin
          if (chan_phase[c] == AWAIT_CMD) chan_cmd[c] = b;
          r.position     = pos;
          r.command_code = chan_cmd[c];
          r.packet_size  = chan_size[c];
          if (int'(pos) + 1 >= int'(chan_size[c])) begin
            r.last = 1'b1;
            clear_parser(c);
            packets_done++;
          end else begin
            chan_count[c] = pos + 16'd1;
            chan_phase[c] = IN_BODY;
          end
        end
        default: begin
          // error phase swallows bytes until a restart
          r.status = ST_DISCARD;
        end
      endcase
    end
    return r;
  endfunction

  // gap lengths: mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void plan_push(input int unsigned c, input logic rs, input logic [7:0] b);
    plan_mem[c][plan_len[c]] = {rs, b};
    plan_len[c]++;
  endfunction

  // lays out the next byte run of one channel: mostly good packets, some broken
  function automatic void plan_packet(input int unsigned c);
    int unsigned kind;
    int unsigned size;
    int unsigned min_len;
    int unsigned hi;
    int unsigned i;
    logic        long_hdr;
    logic [7:0]  hdr;
    plan_len[c] = 0;
    plan_idx[c] = 0;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      // stray restart on a quiet channel
      plan_push(c, 1'b1, 8'($urandom));
      return;
    end
    if (kind < 12) begin
      // junk header, a few discarded bytes, then restart
      do hdr = 8'($urandom); while (hdr == HDR_SHORT || hdr == HDR_LONG);
      plan_push(c, 1'b0, hdr);
      repeat ($urandom_range(0, 3)) plan_push(c, 1'b0, 8'($urandom));
      plan_push(c, 1'b1, 8'($urandom));
      return;
    end
    long_hdr = 1'($urandom_range(0, 1));
    min_len = long_hdr ? MIN_LONG : MIN_SHORT;
    if (kind < 20) begin
      // length out of range, above the limit or below the minimum
      if ($urandom_range(0, 1) == 1 && max_size_cfg < 16'hFFFF) begin
        long_hdr = 1'b1;
        hi = 65535 - max_size_cfg;
        if (hi > 20) hi = 20;
        size = max_size_cfg + $urandom_range(1, hi);
      end else begin
        size = $urandom_range(0, min_len - 1);
      end
    end else begin
      hi = (max_size_cfg < 40) ? max_size_cfg : 40;
      if ($urandom_range(0, 3) == 0) size = $urandom_range(min_len, hi);
      else size = $urandom_range(min_len, (hi < 10) ? hi : 10);
    end
    min_len = long_hdr ? MIN_LONG : MIN_SHORT;
    plan_push(c, 1'b0, long_hdr ? HDR_LONG : HDR_SHORT);
    if (long_hdr) plan_push(c, 1'b0, 8'(size >> 8));
    plan_push(c, 1'b0, 8'(size));
    if (size < min_len || size > max_size_cfg) begin
      repeat ($urandom_range(0, 2)) plan_push(c, 1'b0, 8'($urandom));
      plan_push(c, 1'b1, 8'($urandom));
      return;
    end
    for (i = 0; i < size - (long_hdr ? 3 : 2); i++) plan_push(c, 1'b0, 8'($urandom));
    if (kind < 26) begin
      // cut the packet short with a restart
      plan_len[c] = $urandom_range(1, plan_len[c] - 1);
      plan_push(c, 1'b1, 8'($urandom));
    end
  endfunction

  // offers one item and predicts its echo once it is taken
  // valid stays high after acceptance so back-to-back items need no second
  // assignment in one step; anything that waits lowers it first
  task automatic send_byte(input logic [3:0] ch, input logic [7:0] b, input logic rs);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_channel   <= ch;
    in_data_byte <= b;
    in_restart   <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_echoes.push_back(deframe_byte(ch, b, rs));
    bytes_sent++;
  endtask

  // waits for every echo, then lets the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_echoes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_max_size(input logic [15:0] limit);
    wait_drained();
    cfg_valid           <= 1'b1;
    cfg_max_packet_size <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_size_cfg = limit;
    limits_used++;
  endtask

  // interleaves planned runs over channels, often staying on one channel
  task automatic run_random(input int unsigned items);
    int unsigned n;
    int unsigned c;
    logic [8:0]  step;
    c = 0;
    for (n = 0; n < items; n++) begin
      if ($urandom_range(0, 1) == 1) c = $urandom_range(0, CHANNELS - 1);
      if (plan_idx[c] == plan_len[c]) plan_packet(c);
      step = plan_mem[c][plan_idx[c]];
      plan_idx[c]++;
      send_byte(4'(c), step[7:0], step[8]);
    end
  endtask

  // sends whatever is left of each plan so every channel ends idle
  task automatic finish_plans();
    int unsigned c;
    logic [8:0]  step;
    for (c = 0; c < CHANNELS; c++) begin
      while (plan_idx[c] < plan_len[c]) begin
        step = plan_mem[c][plan_idx[c]];
        plan_idx[c]++;
        send_byte(4'(c), step[7:0], step[8]);
      end
    end
  endtask

  // minimum packets, bad lengths, junk header, discard, restarts, byte extremes
  task automatic test_directed_frames();
    send_byte(4'd0, HDR_SHORT, 1'b0);
    send_byte(4'd0, 8'h03, 1'b0);
    send_byte(4'd0, 8'hA5, 1'b0);
    send_byte(4'd1, HDR_LONG, 1'b0);
    send_byte(4'd1, 8'h00, 1'b0);
    send_byte(4'd1, 8'h04, 1'b0);
    send_byte(4'd1, 8'h7E, 1'b0);
    // short length below minimum, then a discarded byte and restart
    send_byte(4'd2, HDR_SHORT, 1'b0);
    send_byte(4'd2, 8'h02, 1'b0);
    send_byte(4'd2, 8'hFF, 1'b0);
    send_byte(4'd2, 8'h00, 1'b1);
    // long length of 3 is below the long minimum
    send_byte(4'd3, HDR_LONG, 1'b0);
    send_byte(4'd3, 8'h00, 1'b0);
    send_byte(4'd3, 8'h03, 1'b0);
    send_byte(4'd3, 8'h5A, 1'b1);
    send_byte(4'd4, 8'h55, 1'b0);
    send_byte(4'd4, 8'hAA, 1'b1);
    // restart on an idle channel
    send_byte(4'd15, 8'hFF, 1'b1);
  endtask

  // limit at both ends of its range
  task automatic test_size_limits();
    write_max_size(16'd4);
    send_byte(4'd6, HDR_SHORT, 1'b0);
    send_byte(4'd6, 8'h04, 1'b0);
    send_byte(4'd6, 8'h10, 1'b0);
    send_byte(4'd6, 8'h20, 1'b0);
    send_byte(4'd7, HDR_SHORT, 1'b0);
    send_byte(4'd7, 8'h05, 1'b0);
    send_byte(4'd7, 8'h33, 1'b1);
    // largest packet accepted, cut short with a restart
    write_max_size(16'hFFFF);
    send_byte(4'd8, HDR_LONG, 1'b0);
    send_byte(4'd8, 8'hFF, 1'b0);
    send_byte(4'd8, 8'hFF, 1'b0);
    send_byte(4'd8, 8'h11, 1'b0);
    send_byte(4'd8, 8'h22, 1'b1);
  endtask

  // random traffic over several limits and idling mixes
  task automatic test_random_traffic();
    logic [15:0] limits [6];
    int unsigned s;
    limits = '{16'd8192, 16'd20, 16'd4, 16'hFFFF, 16'd300, 16'd4};
    limits[5] = 16'($urandom_range(4, 65535));
    for (s = 0; s < 6; s++) begin
      write_max_size(limits[s]);
      send_idle_pct  = (s % 3) * 25;
      recv_stall_pct = ((s / 2) % 3) * 25;
      run_random(80);
      finish_plans();
    end
  endtask

  // receiver holds off while the sender keeps pushing
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holds_asked++;
    run_random(60);
    finish_plans();
    wait_drained();
  endtask

  // receiver: random stalls, plus the long hold-off counted here
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned holds_served;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < recv_stall_pct) begin
      stall_left = idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each taken result with the oldest predicted echo
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{chan: out_channel, data: out_byte, position: out_position,
              command_code: out_command_code, packet_size: out_packet_size,
              first: out_first, last: out_last, status: out_status};
      echoes_seen++;
      if (pending_echoes.size() == 0) begin
        $display("%0t: result with nothing outstanding: ch=%0d byte=%02h status=%0d",
                 $time, got.chan, got.data, got.status);
        bad_echoes++;
      end else begin
        want = pending_echoes.pop_front();
        if (got !== want) begin
          $display("%0t: expected ch=%0d b=%02h pos=%0d cmd=%02h size=%0d f=%0b l=%0b st=%0d",
                   $time, want.chan, want.data, want.position, want.command_code,
                   want.packet_size, want.first, want.last, want.status);
          $display("%0t: actual   ch=%0d b=%02h pos=%0d cmd=%02h size=%0d f=%0b l=%0b st=%0d",
                   $time, got.chan, got.data, got.position, got.command_code,
                   got.packet_size, got.first, got.last, got.status);
          bad_echoes++;
        end
      end
    end
  end

  // handshake activity for the watchdog, and input stall count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_n && in_valid && !in_ready) input_stalls <= input_stalls + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles, %0d echoes outstanding",
             $time, QUIET_LIMIT, pending_echoes.size());
    $display("length_prefixed_packet_deframer verification failed");
    $finish;
  end

  initial begin
    int unsigned c;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_channel          = '0;
    in_data_byte        = '0;
    in_restart          = 1'b0;
    cfg_valid           = 1'b0;
    cfg_max_packet_size = '0;
    send_idle_pct       = 20;
    recv_stall_pct      = 20;
    for (c = 0; c < CHANNELS; c++) begin
      clear_parser(c);
      plan_len[c] = 0;
      plan_idx[c] = 0;
    end
    max_size_cfg = MAX_SIZE_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_size_limits();
    test_random_traffic();
    test_output_backpressure();
    wait_drained();

    $display("sent %0d bytes under %0d limits: %0d packets, %0d framing errors, %0d restarts",
             bytes_sent, limits_used, packets_done, framing_errors, restarts);
    $display("checked %0d echoes, %0d mismatches, input stalled %0d cycles",
             echoes_seen, bad_echoes, input_stalls);
    if (bad_echoes == 0 && pending_echoes.size() == 0) begin
      $display("length_prefixed_packet_deframer verification clean");
    end else begin
      $display("length_prefixed_packet_deframer verification failed");
    end
    $finish;
  end

endmodule
